// File: rtl/core/msa_pkg.sv
// shared types and constants for the mantissa shift-add multiplier
`timescale 1ns / 1ps
`default_nettype none
package msa_pkg;

    localparam int MANTISSA_BITS_DEF = 96;
    localparam int FIELD_BITS        = 96;
    localparam int LOW_BITS          = 64;
    localparam int HIGH_BITS         = 32;

    typedef struct packed {
        logic [LOW_BITS-1:0]  a_low;
        logic [HIGH_BITS-1:0] a_high;
        logic [LOW_BITS-1:0]  b_low;
        logic [HIGH_BITS-1:0] b_high;
    } t_msa_in;

    typedef struct packed {
        logic [LOW_BITS-1:0]  product_low;
        logic [HIGH_BITS-1:0] product_high;
        logic                 overflow;
    } t_msa_out;

    typedef struct packed {
        logic load;
        logic step;
    } t_msa_ctrl;

endpackage
`default_nettype wire

// File: rtl/core/msa_datapath.sv
// multiplicand, accumulator and multiplier registers around one shared adder
`timescale 1ns / 1ps
`default_nettype none
module msa_datapath #(
    parameter int MANTISSA_BITS = msa_pkg::MANTISSA_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire msa_pkg::t_msa_ctrl i_ctrl,
    input  wire msa_pkg::t_msa_in   i_op,
    output msa_pkg::t_msa_out       o_res
);

    localparam int OPW = (MANTISSA_BITS < msa_pkg::FIELD_BITS) ?
                         MANTISSA_BITS : msa_pkg::FIELD_BITS;
    localparam int PW  = 2 * OPW;

    logic [OPW-1:0] r_mcand;
    logic [OPW-1:0] r_acc;
    logic [OPW-1:0] r_mplier;
    logic [OPW-1:0] n_mcand;
    logic [OPW-1:0] n_acc;
    logic [OPW-1:0] n_mplier;
    logic [OPW:0]   w_sum;
    logic [msa_pkg::FIELD_BITS-1:0] w_a;
    logic [msa_pkg::FIELD_BITS-1:0] w_b;
    logic [msa_pkg::FIELD_BITS-1:0] w_lo;
    logic [PW-1:0]  w_prod;

    assign w_a = {i_op.a_high, i_op.a_low};
    assign w_b = {i_op.b_high, i_op.b_low};

    // one multiplier bit retired per step
    assign w_sum = {1'b0, r_acc} + (r_mplier[0] ? {1'b0, r_mcand} : '0);

    always_comb begin
        n_mcand  = r_mcand;
        n_acc    = r_acc;
        n_mplier = r_mplier;
        if (i_ctrl.load) begin
            n_mcand  = w_a[OPW-1:0];
            n_acc    = '0;
            n_mplier = w_b[OPW-1:0];
        end else if (i_ctrl.step) begin
            n_acc    = w_sum[OPW:1];
            n_mplier = {w_sum[0], r_mplier[OPW-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand  <= n_mcand;
        r_acc    <= n_acc;
        r_mplier <= n_mplier;
    end

    assign w_prod = {r_acc, r_mplier};

    always_comb begin
        w_lo          = '0;
        w_lo[OPW-1:0] = r_mplier;
    end

    assign o_res.product_low  = w_lo[msa_pkg::LOW_BITS-1:0];
    assign o_res.product_high = w_lo[msa_pkg::FIELD_BITS-1:msa_pkg::LOW_BITS];
    assign o_res.overflow     = |w_prod[PW-1:MANTISSA_BITS];

endmodule
`default_nettype wire

// File: rtl/core/msa_seq.sv
// step sequencer: load, count the multiplier bits, strobe the result
`timescale 1ns / 1ps
`default_nettype none
module msa_seq #(
    parameter int STEPS = msa_pkg::MANTISSA_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    output logic              o_busy,
    output logic              o_done,
    output msa_pkg::t_msa_ctrl o_ctrl
);

    localparam int CW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic          r_state;
    logic          n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          r_done;
    logic          n_done;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_done      = 1'b0;
        o_ctrl.load = 1'b0;
        o_ctrl.step = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctrl.load = 1'b1;
                    n_cnt       = CW'(STEPS - 1);
                    n_state     = S_RUN;
                end
            end
            S_RUN: begin
                o_ctrl.step = 1'b1;
                n_cnt       = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state == S_RUN);
    assign o_done = r_done;

endmodule
`default_nettype wire

// File: rtl/core/mantissa_shift_add_multiplier.sv
// top level of the mantissa shift-add multiplier
// Unsigned multiply of two mantissas held as 64-bit low and 32-bit high fields.
// A word is taken at a clock edge with start high and busy low. The block then
// runs one shift-add step per cycle through a single adder, one step for each
// of the min(MANTISSA_BITS, 96) multiplier bits (96 by default), and busy stays
// high while the steps run. In the following cycle o_done is high for one
// cycle with the low 96 product bits and the overflow flag on o_res; the
// receiver cannot stall and must take the word then. A new start is taken in
// that same cycle. Multiply by ten is done by driving the second operand with 10.
`timescale 1ns / 1ps
`default_nettype none
module mantissa_shift_add_multiplier #(
    parameter int MANTISSA_BITS = msa_pkg::MANTISSA_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire msa_pkg::t_msa_in i_op,
    output logic                  o_done,
    output msa_pkg::t_msa_out     o_res
);

    localparam int OPW = (MANTISSA_BITS < msa_pkg::FIELD_BITS) ?
                         MANTISSA_BITS : msa_pkg::FIELD_BITS;

    msa_pkg::t_msa_ctrl w_ctrl;

    msa_seq #(
        .STEPS (OPW)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_done),
        .o_ctrl  (w_ctrl)
    );

    msa_datapath #(
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_op   (i_op),
        .o_res  (o_res)
    );

endmodule
`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for the mantissa shift-add multiplier
`timescale 1ns / 1ps
module tb;
    import msa_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_msa_in  i_op;
    logic     o_done;
    t_msa_out o_res;

    t_msa_out expected_products[$];
    int       mismatch_count;
    int       send_idle_pct;
    int       stall_cycles;

    mantissa_shift_add_multiplier #(
        .MANTISSA_BITS(MANTISSA_BITS_DEF)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_op   (i_op),
        .o_done (o_done),
        .o_res  (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_msa_out mul_mantissa(input t_msa_in w);
        logic [2*FIELD_BITS-1:0] full;
        t_msa_out r;
        full = {{FIELD_BITS{1'b0}}, w.a_high, w.a_low}
             * {{FIELD_BITS{1'b0}}, w.b_high, w.b_low};
        r.product_low  = full[LOW_BITS-1:0];
        r.product_high = full[FIELD_BITS-1:LOW_BITS];
        r.overflow     = |full[2*FIELD_BITS-1:FIELD_BITS];
        return r;
    endfunction

    function automatic t_msa_in pack_operands(input logic [FIELD_BITS-1:0] a,
                                              input logic [FIELD_BITS-1:0] b);
        t_msa_in w;
        w.a_low  = a[LOW_BITS-1:0];
        w.a_high = a[FIELD_BITS-1:LOW_BITS];
        w.b_low  = b[LOW_BITS-1:0];
        w.b_high = b[FIELD_BITS-1:LOW_BITS];
        return w;
    endfunction

    // random value of exactly len significant bits
    function automatic logic [FIELD_BITS-1:0] rand_bits(input int len);
        logic [FIELD_BITS-1:0] r;
        r = {$urandom, $urandom, $urandom};
        if (len < FIELD_BITS) begin
            r &= (({{(FIELD_BITS-1){1'b0}}, 1'b1}) << len) - 1;
        end
        if (len > 0) begin
            r[len-1] = 1'b1;
        end
        return r;
    endfunction

    function automatic int gap_cycles();
        int n;
        n = 0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && n < 8) begin
            n++;
        end
        if (send_idle_pct > 0 && $urandom_range(99) < 3) begin
            n = $urandom_range(10, 110);
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input t_msa_in w);
        int n;
        n = gap_cycles();
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        start <= 1'b1;
        i_op  <= w;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        expected_products.push_back(mul_mantissa(w));
    endtask

    always @(posedge i_clk) begin
        t_msa_out want;
        if (i_rst_n && o_done) begin
            if (expected_products.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_res));
            end else begin
                want = expected_products.pop_front();
                if (o_res.product_low !== want.product_low)
                    report_mismatch($sformatf("product_low got %h want %h",
                                              o_res.product_low, want.product_low));
                if (o_res.product_high !== want.product_high)
                    report_mismatch($sformatf("product_high got %h want %h",
                                              o_res.product_high, want.product_high));
                if (o_res.overflow !== want.overflow)
                    report_mismatch($sformatf("overflow got %b want %b",
                                              o_res.overflow, want.overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic test_extremes();
        logic [FIELD_BITS-1:0] ones;
        ones = '1;
        send_word(pack_operands('0, '0));
        send_word(pack_operands('0, ones));
        send_word(pack_operands(ones, '0));
        send_word(pack_operands(96'd1, ones));
        send_word(pack_operands(ones, 96'd1));
        send_word(pack_operands(ones, ones));
        send_word(pack_operands(96'hAAAAAAAAAAAAAAAAAAAAAAAA, 96'h555555555555555555555555));
        send_word(pack_operands(96'h0000000000000000FFFFFFFF, 96'hFFFFFFFF0000000000000000));
    endtask

    task automatic test_times_ten();
        logic [FIELD_BITS-1:0] top;
        top = {FIELD_BITS{1'b1}} / 96'd10;
        send_word(pack_operands(96'd1, 96'd10));
        send_word(pack_operands(top, 96'd10));
        send_word(pack_operands(top + 96'd1, 96'd10));
        send_word(pack_operands('1, 96'd10));
        send_word(pack_operands(96'd10, top));
    endtask

    task automatic test_overflow_edge();
        logic [FIELD_BITS-1:0] p48;
        p48 = 96'd1 << 48;
        send_word(pack_operands(p48, p48));
        send_word(pack_operands(p48 - 96'd1, p48 + 96'd1));
        send_word(pack_operands(96'd1 << 95, 96'd2));
        send_word(pack_operands(96'd1 << 95, 96'd1));
        send_word(pack_operands(96'd1 << 64, 96'd1 << 31));
        send_word(pack_operands(96'd1 << 64, 96'd1 << 32));
        send_word(pack_operands(96'h0000000000000000FFFFFFFF << 32, 96'h00000000FFFFFFFFFFFFFFFF));
    endtask

    task automatic test_random(input int count);
        logic [FIELD_BITS-1:0] a;
        logic [FIELD_BITS-1:0] b;
        int la;
        int kind;
        for (int k = 0; k < count; k++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    a = rand_bits(FIELD_BITS);
                    b = {$urandom, $urandom, $urandom};
                end
                3, 4: begin
                    // lengths that put the product right at the 96-bit boundary
                    la = $urandom_range(1, FIELD_BITS - 1);
                    a = rand_bits(la);
                    b = rand_bits(FIELD_BITS + 1 - la - $urandom_range(0, 1));
                end
                5: begin
                    a = rand_bits($urandom_range(0, FIELD_BITS));
                    b = 96'd10;
                end
                6: begin
                    a = $urandom_range(0, 20);
                    b = rand_bits($urandom_range(0, FIELD_BITS));
                end
                7: begin
                    a = 96'd1 << $urandom_range(0, FIELD_BITS - 1);
                    b = 96'd1 << $urandom_range(0, FIELD_BITS - 1);
                end
                default: begin
                    a = rand_bits($urandom_range(0, FIELD_BITS));
                    b = rand_bits($urandom_range(0, FIELD_BITS));
                end
            endcase
            if ($urandom_range(1) == 1)
                send_word(pack_operands(a, b));
            else
                send_word(pack_operands(b, a));
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_op           <= '0;
        mismatch_count = 0;
        send_idle_pct  = 11;
        stall_cycles   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_times_ten();
        test_overflow_edge();
        send_idle_pct = 11;
        test_random(430);
        send_idle_pct = 56;
        test_random(430);
        send_idle_pct = 0;
        test_random(430);

        start <= 1'b0;
        while (expected_products.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/msa_pkg.sv
rtl/core/msa_datapath.sv
rtl/core/msa_seq.sv
rtl/core/mantissa_shift_add_multiplier.sv
tb/tb.sv
